[hw/rtl/pitm_pkg.sv]
`default_nettype none

package pitm_pkg;

    // Number of ID entries in the table.
    localparam int TABLE_DEPTH = 16;
    localparam int PTR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int VENDOR_W = 16;
    localparam int DEVICE_W = 16;
    localparam int CLASS_W  = 24;
    localparam int INDEX_W  = 4;

    // A zero class mask compares all class bits.
    localparam logic [CLASS_W-1:0] CLASS_ALL = 24'hFFFFFF;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_MATCH = 1'b1;

    // Sequencer step addresses.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] ST_FETCH    = 3'd0;
    localparam logic [STEP_W-1:0] ST_DISPATCH = 3'd1;
    localparam logic [STEP_W-1:0] ST_WRITE    = 3'd2;
    localparam logic [STEP_W-1:0] ST_SCAN     = 3'd3;
    localparam logic [STEP_W-1:0] ST_RESP     = 3'd4;

    // Branch conditions.
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd0;
    localparam logic [COND_W-1:0] COND_ACCEPT    = 3'd1;
    localparam logic [COND_W-1:0] COND_IS_WRITE  = 3'd2;
    localparam logic [COND_W-1:0] COND_SCAN_MORE = 3'd3;
    localparam logic [COND_W-1:0] COND_OUT_TAKEN = 3'd4;

    typedef struct packed {
        logic [VENDOR_W-1:0] vendor;
        logic                vendor_any;
        logic [DEVICE_W-1:0] device;
        logic                device_any;
        logic [CLASS_W-1:0]  cls_code;
        logic [CLASS_W-1:0]  cls_mask;
    } entry_t;

    // One control word per step. The branch goes to tgt_t when the selected
    // condition holds and to tgt_f otherwise.
    typedef struct packed {
        logic              in_ready;
        logic              load;
        logic              write;
        logic              scan;
        logic              out_valid;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] tgt_t;
        logic [STEP_W-1:0] tgt_f;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t cw;
        cw = '0;
        case (step)
            ST_FETCH: begin
                cw.in_ready = 1'b1;
                cw.load     = 1'b1;
                cw.cond     = COND_ACCEPT;
                cw.tgt_t    = ST_DISPATCH;
                cw.tgt_f    = ST_FETCH;
            end
            ST_DISPATCH: begin
                cw.cond  = COND_IS_WRITE;
                cw.tgt_t = ST_WRITE;
                cw.tgt_f = ST_SCAN;
            end
            ST_WRITE: begin
                cw.write = 1'b1;
                cw.cond  = COND_ALWAYS;
                cw.tgt_t = ST_RESP;
                cw.tgt_f = ST_RESP;
            end
            ST_SCAN: begin
                cw.scan  = 1'b1;
                cw.cond  = COND_SCAN_MORE;
                cw.tgt_t = ST_SCAN;
                cw.tgt_f = ST_RESP;
            end
            ST_RESP: begin
                cw.out_valid = 1'b1;
                cw.cond      = COND_OUT_TAKEN;
                cw.tgt_t     = ST_FETCH;
                cw.tgt_f     = ST_RESP;
            end
            default: begin
                cw.cond  = COND_ALWAYS;
                cw.tgt_t = ST_FETCH;
                cw.tgt_f = ST_FETCH;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/pci_id_table_match.sv]
// PCI device-ID table matcher. Write transfers (req_type 0) store one entry of
// the ID table at entry_index; indexes at or beyond the table depth are dropped.
// Match transfers (req_type 1) scan the table from entry 0, one entry per clock,
// until an entry matches, an all-zero terminator entry is reached or the table
// ends, and return matched. Every input transfer yields exactly one result
// transfer; writes always return matched = 0. The block handles one request at a
// time: an input transfer is followed by a dispatch step, then a write step or a
// scan of 1 to TABLE_DEPTH entries, then a result step that waits on m_ready;
// no new input is taken before the result transfer. The scan rate is set by
// the single table read port, stepped once per cycle. After reset the table is
// empty (all entries read as terminators), so every match answers 0 until
// entries are written. Control is a small microcode program: each step's
// control word drives the datapath and selects a branch condition.
`default_nettype none

module pci_id_table_match (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_req_type,
    input  wire logic [pitm_pkg::INDEX_W-1:0]     s_entry_index,
    input  wire logic [pitm_pkg::VENDOR_W-1:0]    s_id_vendor,
    input  wire logic                             s_id_vendor_any,
    input  wire logic [pitm_pkg::DEVICE_W-1:0]    s_id_device,
    input  wire logic                             s_id_device_any,
    input  wire logic [pitm_pkg::CLASS_W-1:0]     s_id_class,
    input  wire logic [pitm_pkg::CLASS_W-1:0]     s_id_class_mask,
    input  wire logic [pitm_pkg::VENDOR_W-1:0]    s_query_vendor,
    input  wire logic [pitm_pkg::DEVICE_W-1:0]    s_query_device,
    input  wire logic [pitm_pkg::CLASS_W-1:0]     s_query_class_code,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_matched
);

    localparam int PTR_W = pitm_pkg::PTR_W;
    localparam int DEPTH = pitm_pkg::TABLE_DEPTH;

    // Sequencer.
    logic [pitm_pkg::STEP_W-1:0] step_reg, step_next;
    pitm_pkg::ctrl_t             cw;
    logic                        cond_true;
    logic                        in_xfer;

    // Request held for the duration of its processing.
    logic                        req_type_reg;
    logic [PTR_W-1:0]            wr_idx_reg;
    logic                        wr_ok_reg;
    pitm_pkg::entry_t            wr_entry_reg;
    logic [pitm_pkg::VENDOR_W-1:0] q_vendor_reg;
    logic [pitm_pkg::DEVICE_W-1:0] q_device_reg;
    logic [pitm_pkg::CLASS_W-1:0]  q_class_reg;

    // Scan pointer and result.
    logic [PTR_W-1:0]            ptr_reg, ptr_next;
    logic                        hit_reg, hit_next;

    // ID table. An entry without its valid bit reads as all zeros, which is
    // a terminator, so reset empties the table at once.
    pitm_pkg::entry_t            tbl_reg [DEPTH];
    logic [DEPTH-1:0]            vld_reg;

    // Entry under the scan pointer and its evaluation.
    pitm_pkg::entry_t            cur;
    logic [pitm_pkg::CLASS_W-1:0] mask_eff;
    logic                        slot_end;
    logic                        cls_hit;
    logic                        id_hit;
    logic                        slot_hit;
    logic                        slot_last;
    logic                        scan_more;

    assign cw      = pitm_pkg::ucode(step_reg);
    assign s_ready = cw.in_ready;
    assign in_xfer = s_valid && s_ready;
    assign m_valid = cw.out_valid;
    assign m_matched = hit_reg;

    always_comb begin
        cur = vld_reg[ptr_reg] ? tbl_reg[ptr_reg] : '0;
        mask_eff = (cur.cls_mask == '0) ? pitm_pkg::CLASS_ALL : cur.cls_mask;
        slot_end = (cur.vendor == '0) && !cur.vendor_any &&
                   (cur.device == '0) && !cur.device_any && (cur.cls_code == '0);
        cls_hit  = (q_class_reg & mask_eff) == (cur.cls_code & mask_eff);
        id_hit   = (cur.vendor_any || (cur.vendor == q_vendor_reg)) &&
                   (cur.device_any || (cur.device == q_device_reg));
        slot_hit = !slot_end && ((cur.cls_code != '0) ? cls_hit : id_hit);
        slot_last = (ptr_reg == PTR_W'(DEPTH - 1));
        scan_more = !slot_end && !slot_hit && !slot_last;
    end

    always_comb begin
        case (cw.cond)
            pitm_pkg::COND_ALWAYS:    cond_true = 1'b1;
            pitm_pkg::COND_ACCEPT:    cond_true = in_xfer;
            pitm_pkg::COND_IS_WRITE:  cond_true = (req_type_reg == pitm_pkg::REQ_WRITE);
            pitm_pkg::COND_SCAN_MORE: cond_true = scan_more;
            pitm_pkg::COND_OUT_TAKEN: cond_true = m_ready;
            default:                  cond_true = 1'b1;
        endcase
        step_next = cond_true ? cw.tgt_t : cw.tgt_f;
    end

    always_comb begin
        ptr_next = ptr_reg;
        hit_next = hit_reg;
        if (cw.load && in_xfer) begin
            ptr_next = '0;
            hit_next = 1'b0;
        end else if (cw.scan) begin
            // The pointer may wrap on the last entry; the scan ends there anyway.
            ptr_next = ptr_reg + PTR_W'(1);
            hit_next = hit_reg | slot_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= pitm_pkg::ST_FETCH;
            ptr_reg  <= '0;
            hit_reg  <= 1'b0;
        end else begin
            step_reg <= step_next;
            ptr_reg  <= ptr_next;
            hit_reg  <= hit_next;
        end
    end

    // Request capture.
    always_ff @(posedge aclk) begin
        if (cw.load && in_xfer) begin
            req_type_reg            <= s_req_type;
            wr_idx_reg              <= PTR_W'(s_entry_index);
            wr_ok_reg               <= (9'(s_entry_index) < 9'(DEPTH));
            wr_entry_reg.vendor     <= s_id_vendor;
            wr_entry_reg.vendor_any <= s_id_vendor_any;
            wr_entry_reg.device     <= s_id_device;
            wr_entry_reg.device_any <= s_id_device_any;
            wr_entry_reg.cls_code   <= s_id_class;
            wr_entry_reg.cls_mask   <= s_id_class_mask;
            q_vendor_reg            <= s_query_vendor;
            q_device_reg            <= s_query_device;
            q_class_reg             <= s_query_class_code;
        end
    end

    // Table write port.
    always_ff @(posedge aclk) begin
        if (cw.write && wr_ok_reg) begin
            tbl_reg[wr_idx_reg] <= wr_entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (cw.write && wr_ok_reg) begin
            vld_reg[wr_idx_reg] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/pitm_checker.sv]
`default_nettype none

module pitm_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic s_req_type,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_matched
);

    logic last_write_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_write_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            last_write_reg <= (s_req_type == pitm_pkg::REQ_WRITE);
        end
    end

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_matched))
        else $error("result changed while stalled");

    // One request at a time: no input transfer while a result is pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid)
        else $error("input taken while a result is pending");

    // An input transfer makes the block busy in the next cycle.
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transfer");

    // Writes always answer no match.
    a_write_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && last_write_reg |-> !m_matched)
        else $error("write request returned a match");

    // No result comes out right after reset.
    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

bind pci_id_table_match pitm_checker u_pitm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_req_type(s_req_type),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_matched (m_matched)
);

`default_nettype wire
